FILE: hw/rtl/dpss_pkg.sv
package dpss_pkg;

  // Field widths of the item, result and configuration beats.
  localparam int SLOT_FIELD_W = 5;
  localparam int STATE_W      = 2;
  localparam int FLAGS_W      = 8;
  localparam int FRAME_W      = 22;
  localparam int CODING_W     = 2;
  localparam int LEVEL_W      = 3;
  localparam int LIMIT_W      = 16;
  localparam int CFG_INDEX_W  = 8;
  localparam int AGE_W        = FRAME_W + 1;

  // Frame numbers wrap at this count.
  localparam logic [AGE_W-1:0] FRAME_WRAP = 23'd2715648;

  // Action codes.
  localparam logic ACT_UPDATE = 1'b0;
  localparam logic ACT_SEND   = 1'b1;

  // Flow state codes.
  localparam logic [STATE_W-1:0] FLOW_FLOWING  = 2'd0;
  localparam logic [STATE_W-1:0] FLOW_FINISHED = 2'd1;

  // Coding restriction codes; anything else means any coding.
  localparam logic [CODING_W-1:0] CODING_GPRS = 2'd0;
  localparam logic [CODING_W-1:0] CODING_GMSK = 2'd1;

  // Status flag bit positions.
  localparam int FLAG_EGPRS   = 0;
  localparam int FLAG_WAIT    = 1;
  localparam int FLAG_CTRL_TS = 2;
  localparam int FLAG_NEED_CT = 3;
  localparam int FLAG_NEWDATA = 4;
  localparam int FLAG_RESEND  = 5;
  localparam int FLAG_WINDOW  = 6;
  localparam int FLAG_KEEP    = 7;

  // Priority levels, lowest to highest.
  localparam logic [LEVEL_W-1:0] LEVEL_NONE    = 3'd0;
  localparam logic [LEVEL_W-1:0] LEVEL_SENT    = 3'd1;
  localparam logic [LEVEL_W-1:0] LEVEL_LOW_AGE = 3'd2;
  localparam logic [LEVEL_W-1:0] LEVEL_NEWDATA = 3'd3;
  localparam logic [LEVEL_W-1:0] LEVEL_HI_AGE  = 3'd4;
  localparam logic [LEVEL_W-1:0] LEVEL_CONTROL = 3'd5;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_AGE_LOW  = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_AGE_HIGH = 8'd1;

  // Register reset values.
  localparam logic [LIMIT_W-1:0] AGE_LOW_RESET  = 16'd43;
  localparam logic [LIMIT_W-1:0] AGE_HIGH_RESET = 16'd433;

  // One slot record as kept in the table (valid is held apart).
  typedef struct packed {
    logic [STATE_W-1:0] flow_state;
    logic [FLAGS_W-1:0] flags;
    logic [FRAME_W-1:0] poll;
  } slot_rec_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_OUT
  } seq_state_t;

endpackage

FILE: hw/rtl/dpss_item_if.sv
interface dpss_item_if import dpss_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                action;
  logic [SLOT_FIELD_W-1:0] slot;
  logic                slot_valid;
  logic [STATE_W-1:0]  flow_state;
  logic [FLAGS_W-1:0]  status_flags;
  logic [FRAME_W-1:0]  last_poll_frame;
  logic [FRAME_W-1:0]  frame_number;
  logic [CODING_W-1:0] coding_limit;

  modport source (
    output valid, action, slot, slot_valid, flow_state, status_flags,
           last_poll_frame, frame_number, coding_limit,
    input  ready
  );
  modport sink (
    input  valid, action, slot, slot_valid, flow_state, status_flags,
           last_poll_frame, frame_number, coding_limit,
    output ready
  );
endinterface

FILE: hw/rtl/dpss_result_if.sv
interface dpss_result_if import dpss_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    granted;
  logic [SLOT_FIELD_W-1:0] grant_slot;
  logic [LEVEL_W-1:0]      grant_level;
  logic                    grant_egprs;

  modport source (
    output valid, granted, grant_slot, grant_level, grant_egprs,
    input  ready
  );
  modport sink (
    input  valid, granted, grant_slot, grant_level, grant_egprs,
    output ready
  );
endinterface

FILE: hw/rtl/dpss_cfg_if.sv
interface dpss_cfg_if import dpss_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [LIMIT_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/dpss_slot_table.sv
module dpss_slot_table import dpss_pkg::*; #(
  parameter int SLOT_COUNT = 32,
  parameter int SLOT_W     = 5
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic [SLOT_W-1:0] wr_idx,
  input  logic              wr_valid,
  input  slot_rec_t         wr_rec,
  input  logic              rd_en,
  input  logic [SLOT_W-1:0] rd_idx,
  output logic              rd_valid,
  output slot_rec_t         rd_rec
);

  slot_rec_t mem [SLOT_COUNT];
  logic      occupied [SLOT_COUNT];

  // Record storage: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_rec;
    end
    if (rd_en) begin
      rd_rec <= mem[rd_idx];
    end
  end

  // Occupancy bits live in flip-flops so reset empties the table at once.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        occupied[i] <= 1'b0;
      end
      rd_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        occupied[wr_idx] <= wr_valid;
      end
      if (rd_en) begin
        rd_valid <= occupied[rd_idx];
      end
    end
  end

endmodule

FILE: hw/rtl/dpss_grade.sv
module dpss_grade import dpss_pkg::*; (
  input  logic                occupied,
  input  slot_rec_t           rec,
  input  logic [FRAME_W-1:0]  frame_number,
  input  logic [CODING_W-1:0] coding_limit,
  input  logic [LIMIT_W-1:0]  age_limit_low,
  input  logic [LIMIT_W-1:0]  age_limit_high,
  output logic [LEVEL_W-1:0]  level
);

  logic [AGE_W-1:0]   fn_ext;
  logic [AGE_W-1:0]   poll_ext;
  logic [AGE_W-1:0]   age;
  logic               ctrl;
  logic               egprs;
  logic               eligible;
  logic               gmsk_ok;
  logic               over_high;
  logic               over_low;
  logic [LEVEL_W-1:0] raw_level;

  // Poll age with frame number wrap.
  always_comb begin
    fn_ext   = AGE_W'(frame_number);
    poll_ext = AGE_W'(rec.poll);
    if (fn_ext >= poll_ext) begin
      age = fn_ext - poll_ext;
    end else begin
      age = fn_ext + FRAME_WRAP - poll_ext;
    end
    over_high = (age > AGE_W'(age_limit_high)) && (age_limit_high != '0);
    over_low  = age > AGE_W'(age_limit_low);
  end

  // Priority grading from flags and age.
  always_comb begin
    ctrl  = rec.flags[FLAG_CTRL_TS];
    egprs = rec.flags[FLAG_EGPRS];
    if (ctrl && rec.flags[FLAG_NEED_CT]) begin
      raw_level = LEVEL_CONTROL;
    end else if (ctrl && over_high) begin
      raw_level = LEVEL_HI_AGE;
    end else if ((rec.flow_state == FLOW_FLOWING && rec.flags[FLAG_NEWDATA]) ||
                 rec.flags[FLAG_RESEND]) begin
      raw_level = LEVEL_NEWDATA;
    end else if (ctrl && over_low && rec.flags[FLAG_KEEP]) begin
      raw_level = LEVEL_LOW_AGE;
    end else if (rec.flags[FLAG_WINDOW]) begin
      raw_level = LEVEL_SENT;
    end else begin
      raw_level = LEVEL_NONE;
    end
  end

  // Skip rules and the coding restriction.
  always_comb begin
    eligible = occupied &&
               (rec.flow_state == FLOW_FLOWING || rec.flow_state == FLOW_FINISHED) &&
               !rec.flags[FLAG_WAIT] &&
               !(coding_limit == CODING_GPRS && egprs);
    if (coding_limit != CODING_GMSK || !egprs) begin
      gmsk_ok = 1'b1;
    end else if (raw_level == LEVEL_CONTROL) begin
      gmsk_ok = 1'b1;
    end else if (raw_level == LEVEL_NEWDATA) begin
      gmsk_ok = !rec.flags[FLAG_RESEND];
    end else begin
      gmsk_ok = 1'b0;
    end
    level = (eligible && gmsk_ok) ? raw_level : LEVEL_NONE;
  end

endmodule

FILE: hw/rtl/downlink_priority_slot_scheduler.sv
// Downlink slot scheduler with round-robin start and six priority levels.
// A status update beat writes one slot record and gives no result; an
// update to a slot at or above SLOT_COUNT is dropped. A send request beat
// walks every slot once from the round-robin pointer, reading one record
// per cycle from the slot table's read port and grading it in one shared
// grading unit. The block takes no new item during a walk. The table is
// usable right after reset: occupancy bits are flip-flops cleared by reset,
// so there is no clearing pass. Configuration writes are taken in any
// cycle and must only be issued while the block is idle.
module downlink_priority_slot_scheduler import dpss_pkg::*; #(
  parameter int SLOT_COUNT = 32
) (
  input  logic   clk,
  input  logic   rst,
  dpss_item_if.sink     item,
  dpss_result_if.source result,
  dpss_cfg_if.sink      cfg
);

  localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
  localparam int EXT_W  = 7;
  localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(SLOT_COUNT - 1);

  seq_state_t state, state_next;

  logic [LIMIT_W-1:0]  age_limit_low;
  logic [LIMIT_W-1:0]  age_limit_high;
  logic [SLOT_W-1:0]   next_slot;
  logic [FRAME_W-1:0]  frame_number;
  logic [CODING_W-1:0] coding_limit;
  logic [CNT_W-1:0]    rd_cnt;
  logic [SLOT_W-1:0]   rd_idx;
  logic                p_vld;
  logic [SLOT_W-1:0]   p_idx;
  logic [LEVEL_W-1:0]  best_level;
  logic [SLOT_W-1:0]   best_idx;
  logic                best_egprs;

  logic                item_beat;
  logic                issue;
  logic                load_out;
  logic                can_load;
  logic                walk_done;
  logic                wr_en;
  logic [EXT_W-1:0]    slot_ext;
  logic [EXT_W-1:0]    best_ext;
  logic                tbl_valid;
  slot_rec_t           tbl_rec;
  slot_rec_t           wr_rec;
  logic [LEVEL_W-1:0]  level;

  // Configuration registers.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      age_limit_low  <= AGE_LOW_RESET;
      age_limit_high <= AGE_HIGH_RESET;
    end else if (cfg.valid) begin
      if (cfg.index == REG_AGE_LOW) begin
        age_limit_low <= cfg.data;
      end else if (cfg.index == REG_AGE_HIGH) begin
        age_limit_high <= cfg.data;
      end
    end
  end

  // Status updates go straight into the table.
  assign item_beat = item.valid && item.ready;
  assign slot_ext  = EXT_W'(item.slot);
  assign wr_en     = item_beat && (item.action == ACT_UPDATE) &&
                     (slot_ext < EXT_W'(SLOT_COUNT));
  assign wr_rec    = '{flow_state: item.flow_state,
                       flags:      item.status_flags,
                       poll:       item.last_poll_frame};

  dpss_slot_table #(
    .SLOT_COUNT (SLOT_COUNT),
    .SLOT_W     (SLOT_W)
  ) u_table (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_idx   (slot_ext[SLOT_W-1:0]),
    .wr_valid (item.slot_valid),
    .wr_rec   (wr_rec),
    .rd_en    (issue),
    .rd_idx   (rd_idx),
    .rd_valid (tbl_valid),
    .rd_rec   (tbl_rec)
  );

  dpss_grade u_grade (
    .occupied       (tbl_valid),
    .rec            (tbl_rec),
    .frame_number   (frame_number),
    .coding_limit   (coding_limit),
    .age_limit_low  (age_limit_low),
    .age_limit_high (age_limit_high),
    .level          (level)
  );

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign walk_done = (rd_cnt == CNT_W'(SLOT_COUNT)) && !p_vld;
  assign can_load  = !result.valid || result.ready;

  // Next state and sequencer controls.
  always_comb begin
    state_next = state;
    item.ready = 1'b0;
    issue      = 1'b0;
    load_out   = 1'b0;
    case (state)
      ST_IDLE: begin
        item.ready = 1'b1;
        if (item.valid && item.action == ACT_SEND) begin
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        issue = rd_cnt != CNT_W'(SLOT_COUNT);
        if (walk_done) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (can_load) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Walk counters, read pipeline and running best.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_cnt     <= '0;
      p_vld      <= 1'b0;
      best_level <= LEVEL_NONE;
    end else begin
      p_vld <= issue;
      if (item_beat && item.action == ACT_SEND) begin
        rd_cnt     <= '0;
        best_level <= LEVEL_NONE;
      end else begin
        if (issue) begin
          rd_cnt <= rd_cnt + CNT_W'(1);
        end
        if (p_vld && level > best_level) begin
          best_level <= level;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_beat && item.action == ACT_SEND) begin
      frame_number <= item.frame_number;
      coding_limit <= item.coding_limit;
      rd_idx       <= next_slot;
    end else if (issue) begin
      rd_idx <= (rd_idx == LAST_IDX) ? '0 : rd_idx + SLOT_W'(1);
    end
    if (issue) begin
      p_idx <= rd_idx;
    end
    if (p_vld && level > best_level) begin
      best_idx   <= p_idx;
      best_egprs <= tbl_rec.flags[FLAG_EGPRS];
    end
  end

  // Round-robin pointer moves past the winner.
  always_ff @(posedge clk) begin
    if (rst) begin
      next_slot <= '0;
    end else if (load_out && best_level != LEVEL_NONE) begin
      next_slot <= (best_idx == LAST_IDX) ? '0 : best_idx + SLOT_W'(1);
    end
  end

  // Result output register.
  assign best_ext = EXT_W'(best_idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (load_out) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      if (best_level != LEVEL_NONE) begin
        result.granted     <= 1'b1;
        result.grant_slot  <= best_ext[SLOT_FIELD_W-1:0];
        result.grant_level <= best_level;
        result.grant_egprs <= best_egprs;
      end else begin
        result.granted     <= 1'b0;
        result.grant_slot  <= '0;
        result.grant_level <= LEVEL_NONE;
        result.grant_egprs <= 1'b0;
      end
    end
  end

  // A granted beat always carries a real priority level.
  a_grant_level: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.granted) |-> (result.grant_level != LEVEL_NONE))
    else $error("granted result without a priority level");

  // A beat with no grant carries all-zero fields.
  a_no_grant_zero: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.granted) |->
      (result.grant_slot == '0 && result.grant_level == LEVEL_NONE &&
       !result.grant_egprs))
    else $error("result without grant has nonzero fields");

  // The round-robin pointer stays inside the table.
  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    EXT_W'(next_slot) < EXT_W'(SLOT_COUNT))
    else $error("round-robin pointer beyond table");

  // Finishing a walk always presents a result beat.
  a_out_loaded: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && can_load) |=> (result.valid && state == ST_IDLE))
    else $error("walk finished without a result beat");

endmodule
